/* hw/rtl/rlkd_pkg.sv */
// ----------------------------------------------------------------------------
// rlkd_pkg
// Shared types and constants for the resistor-ladder keypad debouncer.
// ----------------------------------------------------------------------------
package rlkd_pkg;

    localparam int SAMPLE_W  = 8;   // adc sample width on the port
    localparam int LEVEL_W   = 8;   // key level register width
    localparam int DELTA_W   = 7;   // window half width register width
    localparam int KEY_SLOTS = 7;   // number of level registers
    localparam int KEY_W     = 3;   // key index width
    localparam int COUNT_W   = 8;   // hit counter width
    localparam int CFG_IDX_W = 3;   // configuration index width

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 3'd7;

    // last-decision code for "no key"
    localparam logic [KEY_W-1:0] NO_KEY_CODE = 3'd7;

    // result decision codes
    typedef enum logic [1:0] {
        DEC_IDLE    = 2'd0,
        DEC_NO_KEY  = 2'd1,
        DEC_NEW_KEY = 2'd2,
        DEC_REPEAT  = 2'd3
    } decision_t;

    typedef logic [KEY_SLOTS-1:0][LEVEL_W-1:0] level_array_t;

    // window match result handed from the classifier to the top level
    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] idx;
    } match_t;

endpackage

/* hw/rtl/rlkd_window_match.sv */
// ----------------------------------------------------------------------------
// rlkd_window_match
// Parallel voltage window compares and priority pick of the first matching key.
// ----------------------------------------------------------------------------
module rlkd_window_match
    import rlkd_pkg::*;
#(
    parameter int NUM_KEYS = 7
) (
    input  logic [SAMPLE_W-1:0] sample,
    input  level_array_t        levels,
    input  logic [DELTA_W-1:0]  delta,
    output match_t              match
);

    logic [KEY_SLOTS-1:0] in_win;

    // one window compare per key, sums one bit wider so nothing wraps
    always_comb begin
        logic [LEVEL_W:0] upper;
        logic [LEVEL_W:0] lifted;
        for (int k = 0; k < KEY_SLOTS; k++) begin
            upper  = {1'b0, levels[k]} + (LEVEL_W+1)'(delta);
            lifted = {1'b0, sample} + (LEVEL_W+1)'(delta);
            if (k >= NUM_KEYS) begin
                in_win[k] = 1'b0;
            end else if (k == 0) begin
                in_win[k] = ({1'b0, sample} < upper);
            end else begin
                in_win[k] = ({1'b0, sample} < upper) && (lifted > {1'b0, levels[k]});
            end
        end
    end

    // lowest matching key wins
    always_comb begin
        match.hit = |in_win;
        match.idx = '0;
        for (int k = KEY_SLOTS - 1; k >= 0; k--) begin
            if (in_win[k]) begin
                match.idx = KEY_W'(k);
            end
        end
    end

endmodule

/* hw/rtl/resistor_ladder_keypad_debouncer.sv */
// ----------------------------------------------------------------------------
// resistor_ladder_keypad_debouncer
// Classifies keypad ADC samples into key windows and debounces key presses.
// ----------------------------------------------------------------------------
// Pipeline: a taken sample is held in the input register; its result is
// computed combinationally and loaded into the result register on advance.
// Throughput: one sample per cycle unless m_tready stalls; each register holds
// one transaction, and a sample is taken while a result waits if input is free.
// Reset: synchronous active-low; levels and delta clear to zero, hit counters
// clear, jitter counter loads JITTER_RELOAD, last key is "no key".
// ----------------------------------------------------------------------------
module resistor_ladder_keypad_debouncer
    import rlkd_pkg::*;
#(
    parameter int NUM_KEYS      = 7,
    parameter int STABLE_HITS   = 1,
    parameter int JITTER_RELOAD = 15,
    parameter int SAMPLE_BITS   = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // sample channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [7:0] adc_sample

    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,    // [2:0] key_index, [7:3] zero
    output logic [1:0]           m_tuser,    // [1:0] decision

    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    localparam int JIT_W = $clog2(JITTER_RELOAD + 1);
    localparam logic [JIT_W-1:0]    JitReload  = JIT_W'(JITTER_RELOAD);
    localparam logic [COUNT_W-1:0]  StableLim  = COUNT_W'(STABLE_HITS);
    localparam logic [SAMPLE_W-1:0] SampleMask =
        (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    level_array_t              levels_reg;
    logic [DELTA_W-1:0]        delta_reg;
    logic [COUNT_W-1:0]        hit_counts_reg [KEY_SLOTS];
    logic [JIT_W-1:0]          jitter_reg;
    logic [KEY_W-1:0]          last_reg;

    logic                      in_valid_reg;
    logic [SAMPLE_W-1:0]       in_sample_reg;
    logic                      out_valid_reg;
    decision_t                 out_dec_reg;
    logic [KEY_W-1:0]          out_key_reg;

    match_t                    match;
    logic                      advance;
    logic                      take_item;
    logic [COUNT_W-1:0]        prior_count;
    logic                      reported;
    logic                      decide;
    decision_t                 dec_next;
    logic [KEY_W-1:0]          key_next;

    // configuration writes always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg <= '0;
            delta_reg  <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_WINDOW) begin
                delta_reg <= cfg_data[DELTA_W-1:0];
            end else begin
                levels_reg[cfg_index] <= cfg_data;
            end
        end
    end

    // handshake: the pipeline moves when the result register is free or drains
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign take_item = in_valid_reg && advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_sample_reg <= s_tdata & SampleMask;
        end
    end

    rlkd_window_match #(
        .NUM_KEYS (NUM_KEYS)
    ) u_match (
        .sample (in_sample_reg),
        .levels (levels_reg),
        .delta  (delta_reg),
        .match  (match)
    );

    // debounce decision
    always_comb begin
        prior_count = hit_counts_reg[match.idx];
        reported    = match.hit && (prior_count > StableLim);
        decide      = reported || (jitter_reg == '0);
        if (reported) begin
            dec_next = (match.idx == last_reg) ? DEC_REPEAT : DEC_NEW_KEY;
            key_next = match.idx;
        end else if (jitter_reg == '0) begin
            dec_next = DEC_NO_KEY;
            key_next = '0;
        end else begin
            dec_next = DEC_IDLE;
            key_next = '0;
        end
    end

    // debounce state: hit counters, jitter counter, last reported key
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < KEY_SLOTS; k++) begin
                hit_counts_reg[k] <= '0;
            end
            jitter_reg <= JitReload;
            last_reg   <= NO_KEY_CODE;
        end else if (take_item) begin
            if (decide) begin
                for (int k = 0; k < KEY_SLOTS; k++) begin
                    hit_counts_reg[k] <= '0;
                end
                jitter_reg <= JitReload;
                last_reg   <= reported ? match.idx : NO_KEY_CODE;
            end else begin
                jitter_reg <= jitter_reg - JIT_W'(1);
                if (match.hit && (prior_count != {COUNT_W{1'b1}})) begin
                    hit_counts_reg[match.idx] <= prior_count + COUNT_W'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_item) begin
            out_dec_reg <= dec_next;
            out_key_reg <= key_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - KEY_W){1'b0}}, out_key_reg};
    assign m_tuser  = out_dec_reg;

    // any decision reloads the jitter counter
    assert property (@(posedge aclk) disable iff (!aresetn)
        take_item && decide |=> jitter_reg == JitReload)
        else $error("jitter counter not reloaded after decision");

    // idle scans count the jitter counter down by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        take_item && !decide |=> jitter_reg == $past(jitter_reg) - JIT_W'(1))
        else $error("jitter counter did not count down");

    // a key equal to the last one is reported as a repeat
    assert property (@(posedge aclk) disable iff (!aresetn)
        take_item && reported && (match.idx == last_reg) |=> out_dec_reg == DEC_REPEAT)
        else $error("repeated key not flagged");

    // a reported key lies inside the configured key range
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_dec_reg == DEC_NEW_KEY || out_dec_reg == DEC_REPEAT)
            |-> out_key_reg < KEY_W'(NUM_KEYS))
        else $error("reported key out of range");

endmodule
